// ===== hdl/dpp_pkg.sv =====
// Shared types, constants and helper functions for the depth pixel to point block.
// Used by every module in hdl/; depends on nothing else.

package dpp_pkg;

    // Field widths
    localparam int DEPTH_W  = 16;
    localparam int COORD_W  = 12;
    localparam int CFG_W    = 16;
    localparam int MAG_W    = 16;
    localparam int PROD_W   = 32;
    localparam int NUM_W    = PROD_W + 4;
    localparam int OUT_W    = 32;

    // One quotient bit per divider step
    localparam int DIV_STEPS = NUM_W;

    // Image bound; columns and rows at or above it are rejected
    localparam int IMAGE_SIDE_MAX = 4096;
    localparam int SIDE_CMP_W     = 15;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] FOCAL_X_RESET   = 16'd8400;
    localparam logic [CFG_W-1:0] FOCAL_Y_RESET   = 16'd8400;
    localparam logic [CFG_W-1:0] CENTER_X_RESET  = 16'd5112;
    localparam logic [CFG_W-1:0] CENTER_Y_RESET  = 16'd3832;
    localparam logic [CFG_W-1:0] MAX_DEPTH_RESET = 16'd10000;

    // Saturation limits
    localparam logic [NUM_W-1:0] POS_LIMIT = 36'h0_7FFF_FFFF;
    localparam logic [NUM_W-1:0] NEG_LIMIT = 36'h0_8000_0000;

    // Input word
    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
    } pixel_t;

    // Output word
    typedef struct packed {
        logic                    point_valid;
        logic signed [OUT_W-1:0] x_mm_q4;
        logic signed [OUT_W-1:0] y_mm_q4;
        logic [DEPTH_W-1:0]      z_mm;
    } point_t;

    // Camera registers
    typedef struct packed {
        logic [CFG_W-1:0] focal_x_q4;
        logic [CFG_W-1:0] focal_y_q4;
        logic [CFG_W-1:0] center_x_q4;
        logic [CFG_W-1:0] center_y_q4;
        logic [CFG_W-1:0] max_depth_mm;
    } cfg_t;

    // Per-pixel flags carried alongside the division
    typedef struct packed {
        logic               point_valid;
        logic               neg_x;
        logic               neg_y;
        logic               zero_x;
        logic               zero_y;
        logic [DEPTH_W-1:0] depth;
    } meta_t;

    // Partial remainder and shifting numerator/quotient of one axis
    typedef struct packed {
        logic [CFG_W-1:0] rem;
        logic [NUM_W-1:0] qn;
    } axis_t;

    // Word travelling down the divider pipeline
    typedef struct packed {
        meta_t meta;
        axis_t ax;
        axis_t ay;
    } div_word_t;

    // One restoring division step: bring down the next numerator bit,
    // subtract the divisor if it fits, shift the quotient bit in.
    function automatic axis_t div_step(axis_t a, logic [CFG_W-1:0] divisor);
        logic [CFG_W:0] trial;
        logic [CFG_W:0] diff;
        axis_t          r;
        trial = {a.rem, a.qn[NUM_W-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            r.rem = diff[CFG_W-1:0];
            r.qn  = {a.qn[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[CFG_W-1:0];
            r.qn  = {a.qn[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== hdl/depth_pixel_to_point.sv =====
// Depth pixel to camera-frame point: 2 front stages, 36 divider steps, 1 output register;
// throughput one word per cycle unless the output stalls (one-bit-per-stage dividers).
// The whole pipeline holds while a finished word waits at a stalled output.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the camera registers
// with their defaults: focal 8400, centre 5112/3832 (Q12.4), max depth 10000 mm.

module depth_pixel_to_point (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  dpp_pkg::pixel_t                  in_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output dpp_pkg::point_t                  out_word,
    input  logic                             cfg_write,
    input  logic [dpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpp_pkg::CFG_W-1:0]        cfg_data
);

    dpp_pkg::cfg_t      cfg_reg;
    logic               advance;

    logic               stage_valid [0:dpp_pkg::DIV_STEPS];
    dpp_pkg::div_word_t stage_word  [0:dpp_pkg::DIV_STEPS];

    // Camera registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x_q4   <= dpp_pkg::FOCAL_X_RESET;
            cfg_reg.focal_y_q4   <= dpp_pkg::FOCAL_Y_RESET;
            cfg_reg.center_x_q4  <= dpp_pkg::CENTER_X_RESET;
            cfg_reg.center_y_q4  <= dpp_pkg::CENTER_Y_RESET;
            cfg_reg.max_depth_mm <= dpp_pkg::MAX_DEPTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dpp_pkg::CFG_FOCAL_X:   cfg_reg.focal_x_q4   <= cfg_data;
                dpp_pkg::CFG_FOCAL_Y:   cfg_reg.focal_y_q4   <= cfg_data;
                dpp_pkg::CFG_CENTER_X:  cfg_reg.center_x_q4  <= cfg_data;
                dpp_pkg::CFG_CENTER_Y:  cfg_reg.center_y_q4  <= cfg_data;
                dpp_pkg::CFG_MAX_DEPTH: cfg_reg.max_depth_mm <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline moves unless the output word is held
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    dpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .out_valid (stage_valid[0]),
        .out_word  (stage_word[0])
    );

    // Divider chain, one quotient bit per stage
    genvar gi;
    generate
        for (gi = 0; gi < dpp_pkg::DIV_STEPS; gi++)
        begin : g_div
            dpp_div_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .cfg       (cfg_reg),
                .in_valid  (stage_valid[gi]),
                .in_word   (stage_word[gi]),
                .out_valid (stage_valid[gi+1]),
                .out_word  (stage_word[gi+1])
            );
        end
    endgenerate

    dpp_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (stage_valid[dpp_pkg::DIV_STEPS]),
        .in_word   (stage_word[dpp_pkg::DIV_STEPS]),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

// ===== hdl/dpp_front.sv =====
// Front end: pixel range check, centre offset and depth multiply, two register stages.
// Depends on dpp_pkg.

module dpp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  dpp_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  dpp_pkg::pixel_t    in_word,
    output logic               out_valid,
    output dpp_pkg::div_word_t out_word
);

    // Stage 1 registers
    logic                          s1_valid_reg;
    logic                          s1_pv_reg,    s1_pv_next;
    logic                          s1_negx_reg,  s1_negx_next;
    logic                          s1_negy_reg,  s1_negy_next;
    logic [dpp_pkg::MAG_W-1:0]     s1_magx_reg,  s1_magx_next;
    logic [dpp_pkg::MAG_W-1:0]     s1_magy_reg,  s1_magy_next;
    logic [dpp_pkg::DEPTH_W-1:0]   s1_depth_reg;

    // Stage 2 registers
    logic                          s2_valid_reg;
    dpp_pkg::div_word_t            s2_word_reg,  s2_word_next;

    logic [dpp_pkg::MAG_W-1:0]     pos_x;
    logic [dpp_pkg::MAG_W-1:0]     pos_y;
    logic [dpp_pkg::PROD_W-1:0]    prod_x;
    logic [dpp_pkg::PROD_W-1:0]    prod_y;

    // Range check and signed offset from the principal point
    always_comb
    begin
        pos_x = {in_word.pixel_col, 4'b0000};
        pos_y = {in_word.pixel_row, 4'b0000};
        s1_pv_next = (in_word.depth_mm != '0)
                   && (in_word.depth_mm <= cfg.max_depth_mm)
                   && ({3'b000, in_word.pixel_col}
                       < dpp_pkg::SIDE_CMP_W'(dpp_pkg::IMAGE_SIDE_MAX))
                   && ({3'b000, in_word.pixel_row}
                       < dpp_pkg::SIDE_CMP_W'(dpp_pkg::IMAGE_SIDE_MAX));
        s1_negx_next = pos_x < cfg.center_x_q4;
        s1_negy_next = pos_y < cfg.center_y_q4;
        s1_magx_next = s1_negx_next ? (cfg.center_x_q4 - pos_x) : (pos_x - cfg.center_x_q4);
        s1_magy_next = s1_negy_next ? (cfg.center_y_q4 - pos_y) : (pos_y - cfg.center_y_q4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pv_reg    <= s1_pv_next;
            s1_negx_reg  <= s1_negx_next;
            s1_negy_reg  <= s1_negy_next;
            s1_magx_reg  <= s1_magx_next;
            s1_magy_reg  <= s1_magy_next;
            s1_depth_reg <= in_word.depth_mm;
        end
    end

    // Offset times depth, scaled by 16 to keep the Q4 result
    always_comb
    begin
        prod_x = dpp_pkg::PROD_W'(s1_magx_reg) * dpp_pkg::PROD_W'(s1_depth_reg);
        prod_y = dpp_pkg::PROD_W'(s1_magy_reg) * dpp_pkg::PROD_W'(s1_depth_reg);
        s2_word_next.meta.point_valid = s1_pv_reg;
        s2_word_next.meta.neg_x       = s1_negx_reg;
        s2_word_next.meta.neg_y       = s1_negy_reg;
        s2_word_next.meta.zero_x      = prod_x == '0;
        s2_word_next.meta.zero_y      = prod_y == '0;
        s2_word_next.meta.depth       = s1_depth_reg;
        s2_word_next.ax.rem           = '0;
        s2_word_next.ax.qn            = {prod_x, 4'b0000};
        s2_word_next.ay.rem           = '0;
        s2_word_next.ay.qn            = {prod_y, 4'b0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_word_reg <= s2_word_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

endmodule

// ===== hdl/dpp_div_stage.sv =====
// One registered step of the X and Y dividers: one quotient bit per axis.
// Depends on dpp_pkg.

module dpp_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  dpp_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  dpp_pkg::div_word_t in_word,
    output logic               out_valid,
    output dpp_pkg::div_word_t out_word
);

    logic               valid_reg;
    dpp_pkg::div_word_t word_reg, word_next;

    // Divide by the focal lengths, flags pass through untouched
    always_comb
    begin
        word_next.meta = in_word.meta;
        word_next.ax   = dpp_pkg::div_step(in_word.ax, cfg.focal_x_q4);
        word_next.ay   = dpp_pkg::div_step(in_word.ay, cfg.focal_y_q4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/dpp_sat.sv =====
// Output stage: sign, saturation to 32 bits and zeroing of rejected pixels.
// Depends on dpp_pkg.

module dpp_sat (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  dpp_pkg::div_word_t in_word,
    output logic               out_valid,
    output dpp_pkg::point_t    out_word
);

    logic            valid_reg;
    dpp_pkg::point_t word_reg, word_next;

    // Clamp the quotient magnitude and apply the sign
    function automatic logic [dpp_pkg::OUT_W-1:0] to_coord(logic [dpp_pkg::NUM_W-1:0] q,
                                                            logic neg, logic zero);
        logic [dpp_pkg::OUT_W-1:0] mag;
        logic [dpp_pkg::OUT_W-1:0] res;
        if (zero)
        begin
            res = '0;
        end
        else if (neg)
        begin
            mag = (q > dpp_pkg::NEG_LIMIT) ? dpp_pkg::NEG_LIMIT[dpp_pkg::OUT_W-1:0]
                                            : q[dpp_pkg::OUT_W-1:0];
            res = '0 - mag;
        end
        else
        begin
            res = (q > dpp_pkg::POS_LIMIT) ? dpp_pkg::POS_LIMIT[dpp_pkg::OUT_W-1:0]
                                            : q[dpp_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    always_comb
    begin
        if (in_word.meta.point_valid)
        begin
            word_next.point_valid = 1'b1;
            word_next.x_mm_q4 = to_coord(in_word.ax.qn, in_word.meta.neg_x, in_word.meta.zero_x);
            word_next.y_mm_q4 = to_coord(in_word.ay.qn, in_word.meta.neg_y, in_word.meta.zero_y);
            word_next.z_mm    = in_word.meta.depth;
        end
        else
        begin
            word_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/dpp_checker.sv =====
// Port-level checks for depth_pixel_to_point, bound to the top level.
// Depends on dpp_pkg and depth_pixel_to_point.

module dpp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input dpp_pkg::pixel_t               in_word,
    input logic                          out_valid,
    input logic                          out_stall,
    input dpp_pkg::point_t               out_word
);

    // A held output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // A stalled input word stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_word))
        else $error("input word changed while stalled");

    // Back-pressure only comes from a held output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // Rejected pixels carry all-zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.point_valid |->
            out_word.x_mm_q4 == '0 && out_word.y_mm_q4 == '0 && out_word.z_mm == '0)
        else $error("rejected pixel with nonzero coordinates");

    // A produced point always has depth
    a_point_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.point_valid |-> out_word.z_mm != '0)
        else $error("valid point with zero depth");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

// ===== verif/depth_pixel_to_point_tb.sv =====
// Self-checking testbench for depth_pixel_to_point: predicts each projected point and
// checks it against the block's output words under random input gaps and output stalls.
// Depends on hdl/dpp_pkg.sv and hdl/depth_pixel_to_point.sv.
`timescale 1ns / 1ps

module depth_pixel_to_point_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 60;
    localparam int PHASE_WORDS    = 240;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    dpp_pkg::pixel_t                      in_word   = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    dpp_pkg::point_t                      out_word;
    logic                                 cfg_write = 1'b0;
    logic [dpp_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [dpp_pkg::CFG_W-1:0]            cfg_data  = '0;

    // Camera registers as the block should hold them
    dpp_pkg::cfg_t   cam;

    // Words waiting to be offered, and points still owed by the block
    dpp_pkg::pixel_t pixel_backlog[$];
    dpp_pkg::point_t points_due[$];

    int     errors        = 0;
    int     pixels_taken  = 0;
    int     burst_left    = 0;
    int     gap_left      = 0;
    int     hold_left     = 0;
    int     next_hold_at  = 600;
    int     stall_mode    = 0;
    int     mode_left     = 0;
    int     stall_tick    = 0;
    int     idle_cycles   = 0;

    depth_pixel_to_point dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // One axis: trunc((coord*16 - centre) * depth * 16 / focal), saturated to 32 bits
    function automatic logic [dpp_pkg::OUT_W-1:0] project_axis_q4(
            logic [dpp_pkg::COORD_W-1:0] coord,
            logic [dpp_pkg::CFG_W-1:0]   centre,
            logic [dpp_pkg::CFG_W-1:0]   focal,
            logic [dpp_pkg::DEPTH_W-1:0] depth);
        logic [63:0] pos;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] quo;
        logic        neg;
        pos = 64'(coord) << 4;
        neg = pos < 64'(centre);
        mag = neg ? 64'(centre) - pos : pos - 64'(centre);
        num = mag * 64'(depth) * 64'd16;
        if (num == 64'd0)
            return '0;
        // zero focal length saturates toward the sign of the offset
        quo = (focal == '0) ? '1 : num / 64'(focal);
        if (neg)
        begin
            if (quo > 64'h8000_0000)
                quo = 64'h8000_0000;
            return -quo[dpp_pkg::OUT_W-1:0];
        end
        if (quo > 64'h7FFF_FFFF)
            quo = 64'h7FFF_FFFF;
        return quo[dpp_pkg::OUT_W-1:0];
    endfunction

    // Point expected for one pixel under the current camera registers
    function automatic dpp_pkg::point_t project_pixel(dpp_pkg::pixel_t px);
        dpp_pkg::point_t pt;
        pt = '0;
        if (px.depth_mm != '0 && px.depth_mm <= cam.max_depth_mm &&
            int'(px.pixel_col) < dpp_pkg::IMAGE_SIDE_MAX &&
            int'(px.pixel_row) < dpp_pkg::IMAGE_SIDE_MAX)
        begin
            pt.point_valid = 1'b1;
            pt.x_mm_q4 = project_axis_q4(px.pixel_col, cam.center_x_q4, cam.focal_x_q4,
                                         px.depth_mm);
            pt.y_mm_q4 = project_axis_q4(px.pixel_row, cam.center_y_q4, cam.focal_y_q4,
                                         px.depth_mm);
            pt.z_mm    = px.depth_mm;
        end
        return pt;
    endfunction

    task automatic report_mismatch(string what, logic [dpp_pkg::OUT_W-1:0] got,
                                   logic [dpp_pkg::OUT_W-1:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (at %0t)", what, got, want, $realtime);
        errors++;
    endtask

    // Register write; the model follows once the write edge has passed
    task automatic write_reg(logic [dpp_pkg::CFG_IDX_W-1:0] idx,
                             logic [dpp_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            dpp_pkg::CFG_FOCAL_X:   cam.focal_x_q4   = val;
            dpp_pkg::CFG_FOCAL_Y:   cam.focal_y_q4   = val;
            dpp_pkg::CFG_CENTER_X:  cam.center_x_q4  = val;
            dpp_pkg::CFG_CENTER_Y:  cam.center_y_q4  = val;
            dpp_pkg::CFG_MAX_DEPTH: cam.max_depth_mm = val;
            default: ;
        endcase
    endtask

    task automatic set_camera(logic [dpp_pkg::CFG_W-1:0] fx, logic [dpp_pkg::CFG_W-1:0] fy,
                              logic [dpp_pkg::CFG_W-1:0] cx, logic [dpp_pkg::CFG_W-1:0] cy,
                              logic [dpp_pkg::CFG_W-1:0] max_depth);
        write_reg(dpp_pkg::CFG_FOCAL_X, fx);
        write_reg(dpp_pkg::CFG_FOCAL_Y, fy);
        write_reg(dpp_pkg::CFG_CENTER_X, cx);
        write_reg(dpp_pkg::CFG_CENTER_Y, cy);
        write_reg(dpp_pkg::CFG_MAX_DEPTH, max_depth);
    endtask

    // Every word yields a point, so the block is idle once nothing is owed
    task automatic drain();
        while (pixel_backlog.size() != 0 || in_valid || points_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_pixel(int depth, int col, int row);
        dpp_pkg::pixel_t px;
        px.depth_mm  = depth[dpp_pkg::DEPTH_W-1:0];
        px.pixel_col = col[dpp_pkg::COORD_W-1:0];
        px.pixel_row = row[dpp_pkg::COORD_W-1:0];
        pixel_backlog = {pixel_backlog, px};
    endtask

    function automatic logic [dpp_pkg::COORD_W-1:0] random_coord(
            logic [dpp_pkg::CFG_W-1:0] centre);
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return '0;
            1:       return '1;
            2:       return centre[dpp_pkg::CFG_W-1:4];   // pixel that holds the principal point
            default: return dpp_pkg::COORD_W'($urandom_range(0, dpp_pkg::IMAGE_SIDE_MAX - 1));
        endcase
    endfunction

    function automatic dpp_pkg::pixel_t random_pixel();
        dpp_pkg::pixel_t px;
        int              sel;
        int              lim;
        lim = int'(cam.max_depth_mm);
        sel = $urandom_range(0, 19);
        case (sel)
            0:       px.depth_mm = '0;
            1:       px.depth_mm = cam.max_depth_mm;
            2:       px.depth_mm = (lim < 65535)
                                 ? dpp_pkg::DEPTH_W'($urandom_range(lim + 1, 65535)) : '1;
            3:       px.depth_mm = '1;
            4:       px.depth_mm = dpp_pkg::DEPTH_W'(1);
            5:       px.depth_mm = dpp_pkg::DEPTH_W'($urandom_range(0, 65535));
            default: px.depth_mm = (lim > 0) ? dpp_pkg::DEPTH_W'($urandom_range(1, lim)) : '0;
        endcase
        px.pixel_col = random_coord(cam.center_x_q4);
        px.pixel_row = random_coord(cam.center_y_q4);
        return px;
    endfunction

    function automatic logic [dpp_pkg::CFG_W-1:0] random_focal();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return '0;
            1:       return dpp_pkg::CFG_W'($urandom_range(1, 16));
            2:       return '1;
            3:       return dpp_pkg::CFG_W'($urandom_range(0, 65535));
            default: return dpp_pkg::CFG_W'($urandom_range(2000, 20000));
        endcase
    endfunction

    function automatic logic [dpp_pkg::CFG_W-1:0] random_centre();
        if ($urandom_range(0, 1) == 0)
            return dpp_pkg::CFG_W'($urandom_range(0, 65535));
        return dpp_pkg::CFG_W'($urandom_range(0, (dpp_pkg::IMAGE_SIDE_MAX - 1) * 16));
    endfunction

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin : driver
        logic offer;
        offer = in_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                points_due = {points_due, project_pixel(in_word)};
                pixels_taken++;
            end
            // the slot is free unless a word is waiting on a stall
            if (!in_valid || !in_stall)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pixel_backlog.size() != 0)
                begin
                    in_word <= pixel_backlog.pop_front();
                    offer = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        in_valid <= offer;
    end

    // Receiver: stall pattern changes mode now and then; long hold-offs fill the pipeline
    always @(posedge clk)
    begin : receiver
        stall_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (pixels_taken >= next_hold_at)
        begin
            next_hold_at += 900;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 300);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ((stall_tick % 5) < 2);
            endcase
        end
    end

    // Check each accepted point against the oldest prediction
    always @(posedge clk)
    begin : monitor
        dpp_pkg::point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (points_due.size() == 0)
                report_mismatch("word with no point owed", out_word.x_mm_q4, '0);
            else
            begin
                want = points_due.pop_front();
                if (out_word.point_valid !== want.point_valid)
                    report_mismatch("point_valid", dpp_pkg::OUT_W'(out_word.point_valid),
                                    dpp_pkg::OUT_W'(want.point_valid));
                if (out_word.x_mm_q4 !== want.x_mm_q4)
                    report_mismatch("x_mm_q4", out_word.x_mm_q4, want.x_mm_q4);
                if (out_word.y_mm_q4 !== want.y_mm_q4)
                    report_mismatch("y_mm_q4", out_word.y_mm_q4, want.y_mm_q4);
                if (out_word.z_mm !== want.z_mm)
                    report_mismatch("z_mm", dpp_pkg::OUT_W'(out_word.z_mm),
                                    dpp_pkg::OUT_W'(want.z_mm));
            end
        end
    end

    // Watchdog: cycles with work outstanding and nothing moving
    always @(posedge clk)
    begin : watchdog
        if ((pixel_backlog.size() != 0 || in_valid || points_due.size() != 0) &&
            !(in_valid && !in_stall) && !(out_valid && !out_stall))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        cam.focal_x_q4   = dpp_pkg::FOCAL_X_RESET;
        cam.focal_y_q4   = dpp_pkg::FOCAL_Y_RESET;
        cam.center_x_q4  = dpp_pkg::CENTER_X_RESET;
        cam.center_y_q4  = dpp_pkg::CENTER_Y_RESET;
        cam.max_depth_mm = dpp_pkg::MAX_DEPTH_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset defaults: no reading, depth limits, image corners
        queue_pixel(0, 100, 200);
        queue_pixel(1, 0, 0);
        queue_pixel(10000, 4095, 4095);
        queue_pixel(10000, 0, 4095);
        queue_pixel(10001, 319, 239);
        queue_pixel(65535, 0, 0);
        queue_pixel(4000, 320, 240);
        drain();

        // unit focal length drives both axes into saturation
        set_camera(16'd1, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
        queue_pixel(65535, 4095, 0);
        queue_pixel(65535, 0, 4095);
        queue_pixel(65535, 4095, 4095);
        queue_pixel(1, 1, 0);
        drain();

        // zero focal length: saturates by sign, zero on the principal point
        set_camera(16'd0, 16'd0, 16'd5120, 16'd3840, 16'hFFFF);
        queue_pixel(1000, 320, 240);
        queue_pixel(1000, 321, 239);
        queue_pixel(1000, 0, 4095);
        queue_pixel(0, 321, 239);
        drain();

        // largest focal length and centre
        set_camera(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        queue_pixel(65535, 0, 4095);
        queue_pixel(65535, 4095, 0);
        drain();

        // writes to unused indexes change nothing; zero max depth rejects everything
        for (int i = int'(dpp_pkg::CFG_MAX_DEPTH) + 1; i < (1 << dpp_pkg::CFG_IDX_W); i++)
            write_reg(i[dpp_pkg::CFG_IDX_W-1:0], dpp_pkg::CFG_W'($urandom_range(0, 65535)));
        write_reg(dpp_pkg::CFG_MAX_DEPTH, '0);
        queue_pixel(1, 10, 10);
        queue_pixel(65535, 4095, 4095);
        queue_pixel(5000, 320, 240);
        drain();

        // random phases, each under its own camera setting
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       set_camera('1, '1, '1, '1, '1);
                1:       set_camera(16'd1, 16'd1, '0, '0, 16'd1);
                2:       set_camera(dpp_pkg::FOCAL_X_RESET, dpp_pkg::FOCAL_Y_RESET,
                                    dpp_pkg::CENTER_X_RESET, dpp_pkg::CENTER_Y_RESET,
                                    dpp_pkg::MAX_DEPTH_RESET);
                default: set_camera(random_focal(), random_focal(), random_centre(),
                                    random_centre(),
                                    ($urandom_range(0, 2) == 0)
                                        ? dpp_pkg::CFG_W'($urandom_range(1, 65535))
                                        : dpp_pkg::MAX_DEPTH_RESET);
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                pixel_backlog = {pixel_backlog, random_pixel()};
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
